// ===== rtl/masked_byte_pattern_scanner_core_assert.svh =====
// assertion helpers used by the checker file
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MBPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
package mbps_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int REG_BYTES = 32;
   localparam int REG_W = 64;
   localparam int REG_IDX_W = 3;
   localparam int LEN_W = 6;
   localparam int ADDR_W = 64;
   localparam int COUNT_W = 16;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COMPARE_MASK = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MATCH_LIMIT = 3'd6;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] byte_address;
      logic              region_start;
      logic              new_scan;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] match_address;
      logic              limit_reached;
   } rsp_type;

   // settled configuration handed to the matcher
   typedef struct packed {
      logic [LEN_W-1:0]   eff_len;
      logic [COUNT_W-1:0] match_limit;
   } cfg_ctrl_type;

endpackage

// ===== rtl/mbps_csr.sv =====
`timescale 1ns / 1ps
module mbps_csr #(
   parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT,
   localparam int CAP = (PATTERN_MAX < mbps_pkg::REG_BYTES) ? PATTERN_MAX : mbps_pkg::REG_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mbps_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [mbps_pkg::REG_W-1:0]     csr_write_data,
   output logic [CAP-1:0][7:0]            pat_aligned,
   output logic [CAP-1:0]                 mask_aligned,
   output mbps_pkg::cfg_ctrl_type         ctrl
);
   import mbps_pkg::*;

   localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;

   logic [3:0][REG_W-1:0]     pat_ff;
   logic [31:0]               mask_ff;
   logic [LEN_W-1:0]          len_ff;
   logic [COUNT_W-1:0]        limit_ff;
   logic [REG_BYTES-1:0][7:0] pat_bytes;
   logic [CAP-1:0][7:0]       pat_cap;
   logic [CAP-1:0]            mask_cap;
   logic [LEN_W-1:0]          eff_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= '0;
         mask_ff  <= '1;
         len_ff   <= LEN_W'(1);
         limit_ff <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PATTERN_0:      pat_ff[0] <= csr_write_data;
            REG_PATTERN_1:      pat_ff[1] <= csr_write_data;
            REG_PATTERN_2:      pat_ff[2] <= csr_write_data;
            REG_PATTERN_3:      pat_ff[3] <= csr_write_data;
            REG_COMPARE_MASK:   mask_ff   <= csr_write_data[31:0];
            REG_PATTERN_LENGTH: len_ff    <= csr_write_data[LEN_W-1:0];
            REG_MATCH_LIMIT:    limit_ff  <= csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign pat_bytes = pat_ff;
   assign pat_cap   = pat_bytes[CAP-1:0];
   assign mask_cap  = mask_ff[CAP-1:0];

   // zero acts as one, oversize clamps to what the window holds
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(CAP)) begin
         eff_len = LEN_W'(CAP);
      end else begin
         eff_len = len_ff;
      end
   end

   // window entry j (0 = newest) lines up with pattern byte eff_len-1-j
   always_comb begin
      logic [LEN_W-1:0] src;
      for (int j = 0; j < CAP; j++) begin
         src = eff_len - LEN_W'(1) - LEN_W'(j);
         pat_aligned[j] = pat_cap[src[IW-1:0]];
         mask_aligned[j] = (LEN_W'(j) < eff_len) ? mask_cap[src[IW-1:0]] : 1'b0;
      end
   end

   assign ctrl.eff_len     = eff_len;
   assign ctrl.match_limit = (limit_ff == '0) ? COUNT_W'(1) : limit_ff;

endmodule

// ===== rtl/mbps_matcher.sv =====
`timescale 1ns / 1ps
module mbps_matcher #(
   parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT,
   localparam int CAP = (PATTERN_MAX < mbps_pkg::REG_BYTES) ? PATTERN_MAX : mbps_pkg::REG_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  mbps_pkg::req_type      req,
   input  logic [CAP-1:0][7:0]    pat_aligned,
   input  logic [CAP-1:0]         mask_aligned,
   input  mbps_pkg::cfg_ctrl_type ctrl,
   output logic                   hit,
   output mbps_pkg::rsp_type      result
);
   import mbps_pkg::*;

   logic [CAP-1:0][7:0] win_ff, win_in;
   logic [LEN_W-1:0]    fill_ff, fill_in, fill_base;
   logic [COUNT_W-1:0]  count_ff, count_in, count_base, count_inc;
   logic                stopped_ff, stopped_in, stopped_base;
   logic                clr;
   logic [CAP-1:0]      pos_ok;
   logic                last;

   assign clr = req.region_start | req.new_scan;

   // shift in the new byte, old bytes drop out on a region or scan start
   always_comb begin
      win_in[0] = req.data_byte;
      for (int k = 1; k < CAP; k++) begin
         win_in[k] = clr ? 8'h00 : win_ff[k-1];
      end
   end

   assign fill_base = clr ? '0 : fill_ff;
   assign fill_in   = (fill_base < LEN_W'(CAP)) ? fill_base + LEN_W'(1) : fill_base;

   assign stopped_base = req.new_scan ? 1'b0 : stopped_ff;
   assign count_base   = req.new_scan ? '0 : count_ff;
   assign count_inc    = (count_base != '1) ? count_base + COUNT_W'(1) : count_base;

   always_comb begin
      for (int j = 0; j < CAP; j++) begin
         pos_ok[j] = !mask_aligned[j] || (win_in[j] == pat_aligned[j]);
      end
   end

   assign hit  = !stopped_base && (fill_in >= ctrl.eff_len) && (&pos_ok);
   assign last = count_inc >= ctrl.match_limit;

   assign count_in   = hit ? count_inc : count_base;
   assign stopped_in = hit ? last : stopped_base;

   assign result.match_address = req.byte_address - (ADDR_W'(ctrl.eff_len) - ADDR_W'(1));
   assign result.limit_reached = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         fill_ff    <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         win_ff     <= win_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== rtl/mbps_out_buf.sv =====
`timescale 1ns / 1ps
module mbps_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbps_pkg::rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mbps_pkg::rsp_type rsp_payload
);
   import mbps_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;

   assign pop         = rsp_valid & rsp_ready;
   assign space       = (count_ff != 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      priority if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== rtl/masked_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps
// masked byte pattern scanner: takes one memory byte per beat with its address and
// region/scan start flags, and reports the address of the first byte of every place
// where the newest pattern_length bytes match the configured pattern (mask bit clear =
// wildcard, overlapping hits all reported, no hit across a region start, reporting stops
// after match_limit hits until a new scan). a byte is taken every cycle the two-entry
// result buffer has room; its result, if any, enters that buffer in the cycle the byte
// is accepted, from a parallel compare of the whole window against the aligned pattern
// between the window registers and the buffer, which lets a byte enter while an earlier
// result waits; req_ready drops only when both entries are taken. the user must write
// configuration via the csr port only while no beat is in flight; not enforced.
module masked_byte_pattern_scanner_core #(
   parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // input beats
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mbps_pkg::req_type              req_payload,
   // result beats
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mbps_pkg::rsp_type              rsp_payload,
   // configuration writes
   input  logic                           csr_write_enable,
   input  logic [mbps_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [mbps_pkg::REG_W-1:0]     csr_write_data
);
   import mbps_pkg::*;

   // only the bytes the pattern registers can hold are ever compared
   localparam int CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

   logic [CAP-1:0][7:0] pat_aligned;
   logic [CAP-1:0]      mask_aligned;
   cfg_ctrl_type        ctrl;
   logic                accept;
   logic                hit;
   rsp_type             result;
   logic                space;

   // a beat is taken whenever the result buffer has a free entry
   assign req_ready = space;
   assign accept    = req_valid & req_ready;

   // config registers plus pattern/mask rotated to window order
   mbps_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pat_aligned      (pat_aligned),
      .mask_aligned     (mask_aligned),
      .ctrl             (ctrl)
   );

   // byte window, fill level, match count and stop flag, plus the compare
   mbps_matcher #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_matcher (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_payload),
      .pat_aligned  (pat_aligned),
      .mask_aligned (mask_aligned),
      .ctrl         (ctrl),
      .hit          (hit),
      .result       (result)
   );

   // hits land in the result buffer in the cycle their byte is accepted
   mbps_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (accept & hit),
      .push_data   (result),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/mbps_checker.sv =====
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_core_assert.svh"
module mbps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mbps_pkg::rsp_type rsp_payload
);
   import mbps_pkg::*;

   // a stalled result stays offered
   `MBPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // and keeps its payload
   `MBPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // input only backs up while results are waiting
   `MBPS_ASSERT_IMPL(a_full_has_rsp, clock, reset, !req_ready, rsp_valid)

   // draining a result with no new byte always frees room
   `MBPS_ASSERT_NEXT(a_drain_frees, clock, reset,
      rsp_valid && rsp_ready && !(req_valid && req_ready), req_ready)

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_checker (.*);
